// File: rtl/core/drmt_pkg.sv
package drmt_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 6;
  localparam int AREA_W      = 2 * COORD_BITS;
  localparam int SUM_W       = AREA_W + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [AREA_W-1:0]     area_t;
  typedef logic [SUM_W-1:0]      sum_t;

  localparam coord_t SCREEN_W_RST = COORD_BITS'(640);
  localparam coord_t SCREEN_H_RST = COORD_BITS'(480);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FULL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OC_APPENDED = 3'd0,
    OC_MERGED   = 3'd1,
    OC_COVERED  = 3'd2,
    OC_FULL     = 3'd3,
    OC_CLEARED  = 3'd4,
    OC_ENTRY    = 3'd5,
    OC_EMPTY    = 3'd6
  } outcome_t;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_RESOLVE,
    ST_RD_REQ,
    ST_RD_EMIT
  } state_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } box_t;

  typedef struct packed {
    cmd_t   cmd;
    coord_t rect_left;
    coord_t rect_top;
    coord_t rect_right;
    coord_t rect_bottom;
  } in_item_t;

  typedef struct packed {
    coord_t           out_left;
    coord_t           out_top;
    coord_t           out_right;
    coord_t           out_bottom;
    logic [CNT_W-1:0] entry_count;
    outcome_t         outcome;
    logic             last;
  } out_item_t;

endpackage

// File: rtl/core/dirty_rect_merge_table.sv
// dirty rectangle table with merge
// in channel (in_valid/in_ready/in_data): one command per transfer; add a
// rectangle, set full screen, clear, or read out the table.
// out channel (out_valid/out_ready/out_data): one result per command, or one
// per stored entry for a read-out, with last set on the final one.
// cfg channel: screen_width (index 0) and screen_height (index 1), always
// ready; write only while the block is idle.
// full screen, clear, empty read and add to an empty or full table load
// their result in the dispatch state after the transfer. an add against a
// non-empty table scans it: the table sits in one single-port-read memory,
// one entry is read per cycle, and containment and best merge are judged
// in the same pass behind a two-stage compare/area pipeline; the result is
// resolved once that pipeline has drained.
// a read-out reads each entry, then presents it once the output is free.
// a new command is taken only once the previous one has loaded its last
// result into the output register, so the next item can enter while that
// result still waits; if the receiver stalls, the block waits with its
// result pending and holds the output stable.
// reset empties the table (entry count zero) and loads 640 x 480; the memory
// contents are not cleared.
module dirty_rect_merge_table
  import drmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  coord_t    cfg_data
);

  function automatic coord_t ext(input coord_t lo, input coord_t hi);
    ext = (hi > lo) ? coord_t'(hi - lo) : '0;
  endfunction

  state_t    state_r, state_nxt;
  idx_t      used_r, used_nxt;
  idx_t      idx_r, idx_nxt;
  coord_t    scr_w_r, scr_h_r;
  cmd_t      cmd_r;
  box_t      nr_r;
  area_t     a2_r;

  box_t      mem [MAX_ENTRIES];
  box_t      rd_data_r;
  logic      mem_we, mem_re;
  idx_t      mem_waddr, mem_raddr;
  box_t      mem_wdata;

  logic      v1_r, v2_r;
  idx_t      p1_idx_r, s_idx_r;
  logic      s_cov_r;
  box_t      s_entry_r, s_union_r;
  area_t     s_ae_r, s_au_r;

  logic      cov_found_r, found_r;
  box_t      cov_box_r, best_union_r;
  sum_t      best_gain_r;
  idx_t      best_idx_r;
  logic      trk_clr;

  logic      out_valid_r;
  out_item_t out_data_r, out_nxt;
  logic      out_load, slot_free;
  box_t      full_box;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;
  assign full_box  = '{l: '0, t: '0, r: scr_w_r, b: scr_h_r};

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // command capture and area of the new rectangle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data.cmd;
      nr_r  <= '{l: in_data.rect_left, t: in_data.rect_top,
                 r: in_data.rect_right, b: in_data.rect_bottom};
    end
    if (state_r == ST_DISPATCH) begin
      a2_r <= area_t'(ext(nr_r.l, nr_r.r)) * area_t'(ext(nr_r.t, nr_r.b));
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // scan stage a: containment, union and both areas
  box_t  e_c, u_c;
  logic  cov_c;
  always_comb begin
    e_c   = rd_data_r;
    cov_c = (e_c.l <= nr_r.l) && (e_c.t <= nr_r.t) &&
            (e_c.r >= nr_r.r) && (e_c.b >= nr_r.b);
    u_c.l = (e_c.l < nr_r.l) ? e_c.l : nr_r.l;
    u_c.t = (e_c.t < nr_r.t) ? e_c.t : nr_r.t;
    u_c.r = (e_c.r > nr_r.r) ? e_c.r : nr_r.r;
    u_c.b = (e_c.b > nr_r.b) ? e_c.b : nr_r.b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= mem_re && (state_r == ST_SCAN);
      v2_r <= v1_r;
    end
    p1_idx_r <= mem_raddr;
    if (v1_r) begin
      s_idx_r   <= p1_idx_r;
      s_cov_r   <= cov_c;
      s_entry_r <= e_c;
      s_union_r <= u_c;
      s_ae_r    <= area_t'(ext(e_c.l, e_c.r)) * area_t'(ext(e_c.t, e_c.b));
      s_au_r    <= area_t'(ext(u_c.l, u_c.r)) * area_t'(ext(u_c.t, u_c.b));
    end
  end

  // scan stage b: first covering entry and best saving, earliest on ties
  sum_t sum_c, au_c, gain_c;
  logic upd_c;
  always_comb begin
    sum_c  = sum_t'(s_ae_r) + sum_t'(a2_r);
    au_c   = sum_t'(s_au_r);
    gain_c = sum_c - au_c;
    upd_c  = v2_r && (au_c < sum_c) && (!found_r || (gain_c > best_gain_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_found_r <= 1'b0;
      found_r     <= 1'b0;
    end else if (trk_clr) begin
      cov_found_r <= 1'b0;
      found_r     <= 1'b0;
    end else if (v2_r) begin
      if (s_cov_r && !cov_found_r) begin
        cov_found_r <= 1'b1;
      end
      if (upd_c) begin
        found_r <= 1'b1;
      end
    end
    if (v2_r && s_cov_r && !cov_found_r) begin
      cov_box_r <= s_entry_r;
    end
    if (upd_c) begin
      best_gain_r  <= gain_c;
      best_idx_r   <= s_idx_r;
      best_union_r <= s_union_r;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    idx_nxt   = idx_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = nr_r;
    mem_re    = 1'b0;
    mem_raddr = idx_r;
    out_load  = 1'b0;
    out_nxt   = '0;
    trk_clr   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cmd_r)
          CMD_FULL: begin
            if (slot_free) begin
              mem_we    = 1'b1;
              mem_wdata = full_box;
              used_nxt  = idx_t'(1);
              out_load  = 1'b1;
              out_nxt.out_right  = scr_w_r;
              out_nxt.out_bottom = scr_h_r;
              out_nxt.outcome    = OC_FULL;
              state_nxt = ST_IDLE;
            end
          end
          CMD_CLEAR: begin
            if (slot_free) begin
              used_nxt  = '0;
              out_load  = 1'b1;
              out_nxt.outcome = OC_CLEARED;
              state_nxt = ST_IDLE;
            end
          end
          CMD_READ: begin
            if (used_r == '0) begin
              if (slot_free) begin
                out_load  = 1'b1;
                out_nxt.outcome = OC_EMPTY;
                state_nxt = ST_IDLE;
              end
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_RD_REQ;
            end
          end
          CMD_ADD: begin
            if (used_r == '0) begin
              if (slot_free) begin
                mem_we    = 1'b1;
                used_nxt  = idx_t'(1);
                out_load  = 1'b1;
                out_nxt.out_left   = nr_r.l;
                out_nxt.out_top    = nr_r.t;
                out_nxt.out_right  = nr_r.r;
                out_nxt.out_bottom = nr_r.b;
                out_nxt.outcome    = OC_APPENDED;
                state_nxt = ST_IDLE;
              end
            end else if (used_r >= idx_t'(MAX_ENTRIES - 1)) begin
              // table at capacity collapses to one full-screen entry
              if (slot_free) begin
                mem_we    = 1'b1;
                mem_wdata = full_box;
                used_nxt  = idx_t'(1);
                out_load  = 1'b1;
                out_nxt.out_right  = scr_w_r;
                out_nxt.out_bottom = scr_h_r;
                out_nxt.outcome    = OC_FULL;
                state_nxt = ST_IDLE;
              end
            end else begin
              idx_nxt   = '0;
              trk_clr   = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        mem_re = 1'b1;
        if (idx_r == idx_t'(used_r - idx_t'(1))) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + idx_t'(1);
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (cov_found_r) begin
            out_nxt.out_left   = cov_box_r.l;
            out_nxt.out_top    = cov_box_r.t;
            out_nxt.out_right  = cov_box_r.r;
            out_nxt.out_bottom = cov_box_r.b;
            out_nxt.outcome    = OC_COVERED;
          end else if (found_r) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_r;
            mem_wdata = best_union_r;
            out_nxt.out_left   = best_union_r.l;
            out_nxt.out_top    = best_union_r.t;
            out_nxt.out_right  = best_union_r.r;
            out_nxt.out_bottom = best_union_r.b;
            out_nxt.outcome    = OC_MERGED;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = used_r;
            used_nxt  = used_r + idx_t'(1);
            out_nxt.out_left   = nr_r.l;
            out_nxt.out_top    = nr_r.t;
            out_nxt.out_right  = nr_r.r;
            out_nxt.out_bottom = nr_r.b;
            out_nxt.outcome    = OC_APPENDED;
          end
        end
      end
      ST_RD_REQ: begin
        mem_re    = 1'b1;
        state_nxt = ST_RD_EMIT;
      end
      ST_RD_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_nxt.out_left   = rd_data_r.l;
          out_nxt.out_top    = rd_data_r.t;
          out_nxt.out_right  = rd_data_r.r;
          out_nxt.out_bottom = rd_data_r.b;
          out_nxt.outcome    = OC_ENTRY;
          if (idx_r == idx_t'(used_r - idx_t'(1))) begin
            state_nxt = ST_IDLE;
          end else begin
            out_nxt.last = 1'b0;
            idx_nxt   = idx_r + idx_t'(1);
            state_nxt = ST_RD_REQ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // every result is final except read-out entries before the last one
    if (!(state_r == ST_RD_EMIT && state_nxt == ST_RD_REQ)) begin
      out_nxt.last = 1'b1;
    end
    out_nxt.entry_count = CNT_W'(used_nxt);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= out_nxt;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r < used_r)
    else $error("scan index beyond table fill");

  a_no_write_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !v1_r && !v2_r)
    else $error("table write while scan pipeline busy");

  a_cleared_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.outcome == OC_CLEARED |-> out_data_r.entry_count == '0)
    else $error("cleared result with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.outcome == OC_FULL |-> out_data_r.entry_count == CNT_W'(1))
    else $error("full screen result with count other than one");

endmodule

// File: bench/tb_dirty_rect_merge_table.sv
`timescale 1ns / 1ps

module tb_dirty_rect_merge_table;
  import drmt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = REG_SCREEN_WIDTH;
  coord_t    cfg_data = '0;

  dirty_rect_merge_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the rectangle table and screen size
  box_t   shadow_rects [MAX_ENTRIES];
  int     shadow_used = 0;
  coord_t scr_w = SCREEN_W_RST;
  coord_t scr_h = SCREEN_H_RST;

  in_item_t  cmd_queue [$];
  out_item_t due_results [$];

  int  errors = 0;
  int  cmds_sent = 0;
  int  results_seen = 0;
  int  outcome_hits [8];
  int  cycles = 0;
  bit  calm = 1'b0;
  bit  hold_arm = 1'b0;
  int  clu_x = 0;
  int  clu_y = 0;

  function automatic longint unsigned span(coord_t lo, coord_t hi);
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  function automatic longint unsigned area_of(box_t b);
    return span(b.l, b.r) * span(b.t, b.b);
  endfunction

  function automatic bit encloses(box_t o, box_t x);
    return o.l <= x.l && o.t <= x.t && o.r >= x.r && o.b >= x.b;
  endfunction

  function automatic box_t bound_of(box_t a, box_t c);
    box_t u;
    u.l = (a.l < c.l) ? a.l : c.l;
    u.t = (a.t < c.t) ? a.t : c.t;
    u.r = (a.r > c.r) ? a.r : c.r;
    u.b = (a.b > c.b) ? a.b : c.b;
    return u;
  endfunction

  function automatic void post(box_t b, outcome_t oc, bit fin);
    out_item_t r;
    r.out_left    = b.l;
    r.out_top     = b.t;
    r.out_right   = b.r;
    r.out_bottom  = b.b;
    r.entry_count = CNT_W'(shadow_used);
    r.outcome     = oc;
    r.last        = fin;
    due_results.push_back(r);
  endfunction

  function automatic void set_full_screen();
    shadow_rects[0] = '{l: '0, t: '0, r: scr_w, b: scr_h};
    shadow_used = 1;
  endfunction

  // works out the results of one accepted command and updates the shadow table
  function automatic void track_command(in_item_t it);
    box_t nr;
    box_t u;
    int i;
    int hit;
    int best;
    longint unsigned a2, sum, au, best_gain;
    nr = '{l: it.rect_left, t: it.rect_top, r: it.rect_right, b: it.rect_bottom};
    case (it.cmd)
      CMD_FULL: begin
        set_full_screen();
        post(shadow_rects[0], OC_FULL, 1'b1);
      end
      CMD_CLEAR: begin
        shadow_used = 0;
        post('0, OC_CLEARED, 1'b1);
      end
      CMD_READ: begin
        if (shadow_used == 0) post('0, OC_EMPTY, 1'b1);
        for (i = 0; i < shadow_used; i++)
          post(shadow_rects[i], OC_ENTRY, i == shadow_used - 1);
      end
      default: begin
        if (shadow_used == 0) begin
          shadow_rects[0] = nr;
          shadow_used = 1;
          post(nr, OC_APPENDED, 1'b1);
        end else if (shadow_used >= MAX_ENTRIES - 1) begin
          set_full_screen();
          post(shadow_rects[0], OC_FULL, 1'b1);
        end else begin
          hit = -1;
          for (i = 0; i < shadow_used; i++)
            if (hit < 0 && encloses(shadow_rects[i], nr)) hit = i;
          if (hit >= 0) begin
            post(shadow_rects[hit], OC_COVERED, 1'b1);
          end else begin
            best = -1;
            best_gain = 0;
            a2 = area_of(nr);
            for (i = 0; i < shadow_used; i++) begin
              u = bound_of(shadow_rects[i], nr);
              sum = area_of(shadow_rects[i]) + a2;
              au = area_of(u);
              // strict compare keeps the earliest entry on a tie
              if (au < sum && (best < 0 || sum - au > best_gain)) begin
                best = i;
                best_gain = sum - au;
              end
            end
            if (best >= 0) begin
              shadow_rects[best] = bound_of(shadow_rects[best], nr);
              post(shadow_rects[best], OC_MERGED, 1'b1);
            end else begin
              shadow_rects[shadow_used] = nr;
              shadow_used++;
              post(nr, OC_APPENDED, 1'b1);
            end
          end
        end
      end
    endcase
  endfunction

  // input side: one command per transfer, with random idle bursts
  int tx_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_command(in_data);
        cmds_sent++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
        tx_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (cmd_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= cmd_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: check each transfer and stall at random
  int        rx_gap = 0;
  int        hold_cnt = 0;
  bit        hold_done = 1'b0;
  out_item_t want;

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual %p",
                   $time, out_data);
        end else begin
          want = due_results.pop_front();
          check_field("out_left", want.out_left, out_data.out_left);
          check_field("out_top", want.out_top, out_data.out_top);
          check_field("out_right", want.out_right, out_data.out_right);
          check_field("out_bottom", want.out_bottom, out_data.out_bottom);
          check_field("entry_count", want.entry_count, out_data.entry_count);
          check_field("outcome", want.outcome, out_data.outcome);
          check_field("last", want.last, out_data.last);
          outcome_hits[want.outcome]++;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        // long back-pressure so the input side stalls
        hold_cnt = LONG_HOLD - 1;
        hold_done = 1'b1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        rx_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, due_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, coord_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic void push_op(cmd_t c);
    in_item_t it;
    it = '0;
    it.cmd = c;
    cmd_queue.push_back(it);
  endfunction

  function automatic void push_add(int l, int t, int r, int b);
    in_item_t it;
    it.cmd         = CMD_ADD;
    it.rect_left   = coord_t'(l);
    it.rect_top    = coord_t'(t);
    it.rect_right  = coord_t'(r);
    it.rect_bottom = coord_t'(b);
    cmd_queue.push_back(it);
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic void push_rand_add();
    int p, a, c, d, e;
    p = $urandom_range(0, 99);
    if (p < 50) begin
      // nearby rectangles, so merges and covers happen
      if ($urandom_range(0, 15) == 0) begin
        clu_x = $urandom_range(0, 3800);
        clu_y = $urandom_range(0, 3800);
      end
      a = clu_x + $urandom_range(0, 150);
      c = clu_y + $urandom_range(0, 150);
      push_add(a, c, a + $urandom_range(0, 80), c + $urandom_range(0, 80));
    end else if (p < 75) begin
      a = $urandom_range(0, 4095);
      c = $urandom_range(0, 4095);
      d = $urandom_range(0, 4095);
      e = $urandom_range(0, 4095);
      push_add(a < c ? a : c, d < e ? d : e, a < c ? c : a, d < e ? e : d);
    end else if (p < 90) begin
      // edges in any order, inverted ones included
      push_add($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      push_add(pick_edge(), pick_edge(), pick_edge(), pick_edge());
    end
  endfunction

  function automatic void push_mix(int n);
    int p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 72) push_rand_add();
      else if (p < 82) push_op(CMD_READ);
      else if (p < 91) push_op(CMD_CLEAR);
      else push_op(CMD_FULL);
    end
  endfunction

  // disjoint rectangles, one per grid cell, so every one is appended
  function automatic void push_grid(int n);
    int i, cx, cy, l, t;
    push_op(CMD_CLEAR);
    for (i = 0; i < n; i++) begin
      cx = (i % 8) * 512;
      cy = (i / 8) * 512;
      l = cx + $urandom_range(0, 400);
      t = cy + $urandom_range(0, 400);
      push_add(l, t, l + $urandom_range(0, 100), t + $urandom_range(0, 100));
    end
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset screen size
    push_op(CMD_READ);
    push_op(CMD_CLEAR);
    push_add(10, 20, 30, 40);
    push_add(12, 22, 28, 38);
    push_add(25, 20, 50, 40);
    push_add(1000, 1000, 1010, 1010);
    push_add(5, 5, 3, 3);
    push_add(4095, 4095, 0, 0);
    push_add(0, 0, 4095, 4095);
    push_op(CMD_READ);
    push_add(4095, 4095, 4095, 4095);
    push_op(CMD_FULL);
    push_add(100, 100, 200, 200);
    push_add(600, 400, 700, 500);
    push_add(0, 0, 0, 0);
    push_op(CMD_CLEAR);
    push_add(4095, 0, 4095, 0);
    push_add(0, 4095, 0, 4095);
    // equal gain against two entries goes to the first
    push_op(CMD_CLEAR);
    push_add(0, 0, 10, 10);
    push_add(20, 0, 30, 10);
    push_add(5, 0, 25, 10);
    push_op(CMD_READ);
    wait_idle();

    write_reg(REG_SCREEN_WIDTH, 12'd4095);
    write_reg(REG_SCREEN_HEIGHT, 12'd4095);
    hold_arm = 1'b1;
    push_mix(120);
    wait_idle();

    write_reg(REG_SCREEN_WIDTH, 12'd1);
    write_reg(REG_SCREEN_HEIGHT, 12'd1);
    push_grid(MAX_ENTRIES - 1);
    push_op(CMD_READ);
    push_rand_add();
    push_op(CMD_READ);
    push_mix(50);
    wait_idle();

    write_reg(REG_SCREEN_WIDTH, coord_t'($urandom_range(1, 4095)));
    write_reg(REG_SCREEN_HEIGHT, coord_t'($urandom_range(1, 4095)));
    push_grid($urandom_range(30, MAX_ENTRIES - 1));
    push_mix(30);
    push_op(CMD_READ);
    wait_idle();

    write_reg(REG_SCREEN_HEIGHT, SCREEN_H_RST);
    write_reg(REG_SCREEN_WIDTH, SCREEN_W_RST);
    calm = 1'b1;
    push_mix(30);
    wait_idle();
    repeat (50) @(posedge clk);

    $display("ran %0d commands over several screen sizes, %0d results checked",
             cmds_sent, results_seen);
    $display("appended %0d, merged %0d, covered %0d, full %0d, cleared %0d, entry %0d, empty %0d",
             outcome_hits[OC_APPENDED], outcome_hits[OC_MERGED], outcome_hits[OC_COVERED],
             outcome_hits[OC_FULL], outcome_hits[OC_CLEARED], outcome_hits[OC_ENTRY],
             outcome_hits[OC_EMPTY]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, due_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
